### src/lfs_pkg.sv
// Shared types and constants of the LED frame store and scan-out block.
package lfs_pkg;

   // Request function codes as they arrive on the input channel
   localparam logic [2:0] FUNC_SET  = 3'd0;
   localparam logic [2:0] FUNC_READ = 3'd1;
   localparam logic [2:0] FUNC_RECT = 3'd2;
   localparam logic [2:0] FUNC_FILL = 3'd3;
   localparam logic [2:0] FUNC_SCAN = 3'd4;

   // Widths that cover the largest supported frame (16 rows by 128 columns)
   localparam int MAX_ADDR_W = 11;
   localparam int COL_W      = 8;
   localparam int ROW_W      = 5;

   // Current sources per driver chip, one scan beat each
   localparam int           SOURCES     = 16;
   localparam int           SRC_W       = 4;
   localparam logic [3:0]   LAST_SOURCE = 4'd15;

   localparam logic [7:0]   GAIN_RESET  = 8'd128;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Operation as classified by the front end
   typedef enum logic [2:0] {
      OP_NOP,
      OP_SET,
      OP_SET_FAIL,
      OP_READ,
      OP_RECT,
      OP_FILL,
      OP_SCAN
   } op_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ONE,
      S_FILL,
      S_RECT,
      S_SCAN
   } state_type;

   // Classified command passed through the queue
   typedef struct packed {
      op_type                  op;
      logic [MAX_ADDR_W-1:0]   addr;
      logic [COL_W-1:0]        x_start;
      logic [COL_W-1:0]        x_end;
      logic [ROW_W-1:0]        y_start;
      logic [ROW_W-1:0]        y_end;
      logic [7:0]              value;
      logic [SRC_W-1:0]        line;
      logic                    on_frame;
   } cmd_type;

   // Back-end control toward the queue
   typedef struct packed {
      logic pop;
      logic clearing;
   } queue_ctl_type;

endpackage

### src/lfs_front.sv
// Front end: classify request beats and hold them in a short queue.
module lfs_front #(
   parameter int ROWS         = 12,
   parameter int CHIP_COLUMNS = 7,
   parameter int COLUMNS      = 42
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_func,
   input  logic [7:0]            req_x_pos,
   input  logic [7:0]            req_y_pos,
   input  logic [7:0]            req_width,
   input  logic [7:0]            req_height,
   input  logic [7:0]            req_pixel_value,
   input  logic [2:0]            req_chip,
   input  logic [3:0]            req_scan_line,
   input  lfs_pkg::queue_ctl_type ctl,
   output logic                  q_valid,
   output lfs_pkg::cmd_type      q_cmd
);

   lfs_pkg::cmd_type                     cmd;
   lfs_pkg::cmd_type                     q_ff [lfs_pkg::QUEUE_DEPTH];
   logic [lfs_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lfs_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lfs_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                 push;

   // Classify the request beat
   always_comb begin
      int  x_i;
      int  y_i;
      int  x_end_i;
      int  y_end_i;
      int  col_i;
      logic in_frame;
      x_i      = int'(req_x_pos);
      y_i      = int'(req_y_pos);
      x_end_i  = int'(8'(req_x_pos + req_width));
      y_end_i  = int'(8'(req_y_pos + req_height));
      if (x_end_i > COLUMNS) begin
         x_end_i = COLUMNS;
      end
      if (y_end_i > ROWS) begin
         y_end_i = ROWS;
      end
      in_frame = (x_i < COLUMNS) && (y_i < ROWS);
      col_i    = int'(req_chip) * CHIP_COLUMNS + (CHIP_COLUMNS - 1 - int'(req_scan_line));

      cmd          = '0;
      cmd.op       = lfs_pkg::OP_NOP;
      cmd.x_start  = lfs_pkg::COL_W'(req_x_pos);
      cmd.x_end    = lfs_pkg::COL_W'(x_end_i);
      cmd.y_start  = lfs_pkg::ROW_W'(req_y_pos);
      cmd.y_end    = lfs_pkg::ROW_W'(y_end_i);
      cmd.value    = req_pixel_value;
      cmd.line     = req_scan_line;
      cmd.on_frame = (int'(req_scan_line) < CHIP_COLUMNS) && (col_i < COLUMNS);
      if (in_frame) begin
         cmd.addr = lfs_pkg::MAX_ADDR_W'(y_i * COLUMNS + x_i);
      end

      unique case (req_func)
         lfs_pkg::FUNC_SET: begin
            cmd.op = in_frame ? lfs_pkg::OP_SET : lfs_pkg::OP_SET_FAIL;
         end
         lfs_pkg::FUNC_READ: begin
            cmd.op = in_frame ? lfs_pkg::OP_READ : lfs_pkg::OP_NOP;
         end
         lfs_pkg::FUNC_RECT: begin
            if (in_frame && (x_end_i > x_i) && (y_end_i > y_i)) begin
               cmd.op = lfs_pkg::OP_RECT;
            end
         end
         lfs_pkg::FUNC_FILL: begin
            cmd.op   = lfs_pkg::OP_FILL;
            cmd.addr = '0;
         end
         lfs_pkg::FUNC_SCAN: begin
            cmd.op   = lfs_pkg::OP_SCAN;
            cmd.addr = cmd.on_frame ? lfs_pkg::MAX_ADDR_W'(col_i) : '0;
         end
         default: begin
            cmd.op = lfs_pkg::OP_NOP;
         end
      endcase
   end

   // Queue bookkeeping
   assign req_ready = (int'(count_ff) < lfs_pkg::QUEUE_DEPTH) && !ctl.clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = ctl.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### src/lfs_back.sv
// Back end: frame memory, fill walker, scan-out scaling and result register.
module lfs_back #(
   parameter int ROWS    = 12,
   parameter int COLUMNS = 42
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             gain,
   input  logic                   q_valid,
   input  lfs_pkg::cmd_type       q_cmd,
   output lfs_pkg::queue_ctl_type ctl,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_data,
   output logic [7:0]             rsp_pwm_index,
   output logic                   rsp_ok,
   output logic [31:0]            rsp_error_count,
   output logic                   rsp_last
);

   localparam int         DEPTH     = ROWS * COLUMNS;
   localparam int         AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

   logic [7:0]                  mem [DEPTH];
   logic [7:0]                  rdata_ff;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [7:0]                  mem_wdata;

   lfs_pkg::state_type          state_ff, state_in;
   lfs_pkg::cmd_type            cmd_ff, cmd_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [AW-1:0]               row_addr_ff, row_addr_in;
   logic [lfs_pkg::COL_W-1:0]   col_ff, col_in;
   logic [lfs_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [lfs_pkg::SRC_W-1:0]   src_ff, src_in;
   logic [31:0]                 fail_ff, fail_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff, rsp_data_in;
   logic [7:0]                  rsp_pwm_index_ff, rsp_pwm_index_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [31:0]                 rsp_error_count_ff, rsp_error_count_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        out_free;
   logic [15:0]                 product;
   logic [16:0]                 quot_sum;
   logic [7:0]                  scaled;
   logic                        src_dark;

   // Scale by gain/255: (p + p/256 + 1)/256 is exact over 16-bit products
   assign product  = 16'(rdata_ff) * 16'(gain);
   assign quot_sum = 17'(product) + 17'(product[15:8]) + 17'd1;
   assign scaled   = quot_sum[15:8];
   assign src_dark = !cmd_ff.on_frame || (int'(src_ff) >= ROWS);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in           = state_ff;
      cmd_in             = cmd_ff;
      addr_in            = addr_ff;
      row_addr_in        = row_addr_ff;
      col_in             = col_ff;
      row_in             = row_ff;
      src_in             = src_ff;
      fail_in            = fail_ff;
      mem_we             = 1'b0;
      mem_waddr          = addr_ff;
      mem_wdata          = cmd_ff.value;
      ctl.pop            = 1'b0;
      ctl.clearing       = (state_ff == lfs_pkg::S_CLEAR);
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_data_in        = rsp_data_ff;
      rsp_pwm_index_in   = rsp_pwm_index_ff;
      rsp_ok_in          = rsp_ok_ff;
      rsp_error_count_in = rsp_error_count_ff;
      rsp_last_in        = rsp_last_ff;

      unique case (state_ff)
         lfs_pkg::S_CLEAR: begin
            // Zero the frame one entry per cycle after reset
            mem_we    = 1'b1;
            mem_wdata = 8'd0;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = lfs_pkg::S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         lfs_pkg::S_IDLE: begin
            if (q_valid) begin
               ctl.pop     = 1'b1;
               cmd_in      = q_cmd;
               addr_in     = q_cmd.addr[AW-1:0];
               row_addr_in = q_cmd.addr[AW-1:0];
               col_in      = q_cmd.x_start;
               row_in      = q_cmd.y_start;
               src_in      = '0;
               unique case (q_cmd.op)
                  lfs_pkg::OP_SET: begin
                     mem_we    = 1'b1;
                     mem_waddr = q_cmd.addr[AW-1:0];
                     mem_wdata = q_cmd.value;
                     state_in  = lfs_pkg::S_ONE;
                  end
                  lfs_pkg::OP_SET_FAIL: begin
                     fail_in  = fail_ff + 32'd1;
                     state_in = lfs_pkg::S_ONE;
                  end
                  lfs_pkg::OP_RECT: state_in = lfs_pkg::S_RECT;
                  lfs_pkg::OP_FILL: state_in = lfs_pkg::S_FILL;
                  lfs_pkg::OP_SCAN: state_in = lfs_pkg::S_SCAN;
                  default:          state_in = lfs_pkg::S_ONE;
               endcase
            end
         end
         lfs_pkg::S_ONE: begin
            // Emit the single result beat
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = (cmd_ff.op == lfs_pkg::OP_READ) ? rdata_ff : 8'd0;
               rsp_pwm_index_in   = 8'd0;
               rsp_ok_in          = (cmd_ff.op != lfs_pkg::OP_SET_FAIL);
               rsp_error_count_in = fail_ff;
               rsp_last_in        = 1'b1;
               state_in           = lfs_pkg::S_IDLE;
            end
         end
         lfs_pkg::S_FILL: begin
            // Sweep the whole frame
            mem_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = lfs_pkg::S_ONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         lfs_pkg::S_RECT: begin
            // Walk the clipped rectangle row by row
            mem_we = 1'b1;
            if (col_ff == lfs_pkg::COL_W'(cmd_ff.x_end - 1'b1)) begin
               if (row_ff == lfs_pkg::ROW_W'(cmd_ff.y_end - 1'b1)) begin
                  state_in = lfs_pkg::S_ONE;
               end else begin
                  row_in      = row_ff + 1'b1;
                  col_in      = cmd_ff.x_start;
                  row_addr_in = row_addr_ff + ROW_STEP;
                  addr_in     = row_addr_ff + ROW_STEP;
               end
            end else begin
               col_in  = col_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         lfs_pkg::S_SCAN: begin
            // Emit one PWM beat per source, advancing down the column
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = src_dark ? 8'd0 : scaled;
               rsp_pwm_index_in   = {cmd_ff.line, src_ff};
               rsp_ok_in          = 1'b1;
               rsp_error_count_in = fail_ff;
               rsp_last_in        = (src_ff == lfs_pkg::LAST_SOURCE);
               if (src_ff == lfs_pkg::LAST_SOURCE) begin
                  state_in = lfs_pkg::S_IDLE;
               end else begin
                  src_in = src_ff + 1'b1;
               end
               if (cmd_ff.on_frame && (int'(src_ff) < ROWS - 1)) begin
                  addr_in = addr_ff + ROW_STEP;
               end
            end
         end
         default: begin
            state_in = lfs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfs_pkg::S_CLEAR;
         addr_ff      <= '0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload and walk registers
   always_ff @(posedge clock) begin
      cmd_ff             <= cmd_in;
      row_addr_ff        <= row_addr_in;
      col_ff             <= col_in;
      row_ff             <= row_in;
      src_ff             <= src_in;
      rsp_data_ff        <= rsp_data_in;
      rsp_pwm_index_ff   <= rsp_pwm_index_in;
      rsp_ok_ff          <= rsp_ok_in;
      rsp_error_count_ff <= rsp_error_count_in;
      rsp_last_ff        <= rsp_last_in;
   end

   // Frame memory: one write port, one registered read at the next address
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_in];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_pwm_index   = rsp_pwm_index_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_error_count = rsp_error_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### src/led_framebuffer_scanout.sv
// Top level of the LED frame store with PWM scan-out and its register port.
//
// Requests arrive on the req_ channel (valid/ready) and produce result beats
// on the rsp_ channel. Set, read, rectangle fill, frame fill and unknown
// functions give one beat each; a scan request gives 16 beats, one per
// current source, with rsp_last on the sixteenth.
// A rectangle fill writes the clipped rectangle and a frame fill the whole frame
// through the single frame memory write port before their result beat. A
// single-beat request passes the sequencer through its idle and result states;
// a scan streams one beat per cycle while the receiver keeps taking them.
// A two-entry queue sits between the request classifier and the executing
// sequencer. The result register reloads in the cycle its beat is taken; a
// stalled receiver stops the sequencer, which then backs up the queue and
// finally drops req_ready.
// Reset sets global_gain to 128, clears the failure count and then zeroes
// the frame memory one entry per cycle, all ROWS*COLUMNS entries (504 at the
// default size), during which req_ready stays low. The gain register at
// byte address 0 of the csr_ port may be written at any time while idle.
module led_framebuffer_scanout #(
   parameter int ROWS         = 12,
   parameter int CHIP_COLUMNS = 7,
   parameter int COLUMNS      = 42
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_func,
   input  logic [7:0]   req_x_pos,
   input  logic [7:0]   req_y_pos,
   input  logic [7:0]   req_width,
   input  logic [7:0]   req_height,
   input  logic [7:0]   req_pixel_value,
   input  logic [2:0]   req_chip,
   input  logic [3:0]   req_scan_line,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_data,
   output logic [7:0]   rsp_pwm_index,
   output logic         rsp_ok,
   output logic [31:0]  rsp_error_count,
   output logic         rsp_last,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [2:0] REG_GAIN_ADDR = 3'd0;

   logic [7:0]              gain_ff, gain_in;
   logic                    csr_write;
   logic                    q_valid;
   lfs_pkg::cmd_type        q_cmd;
   lfs_pkg::queue_ctl_type  ctl;

   // Register port: write on the access phase, zero-wait reads
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign gain_in    = (csr_write && (csr_paddr == REG_GAIN_ADDR)) ? csr_pwdata[7:0] : gain_ff;
   assign csr_prdata = (csr_paddr == REG_GAIN_ADDR) ? {24'd0, gain_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= lfs_pkg::GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   lfs_front #(
      .ROWS         (ROWS),
      .CHIP_COLUMNS (CHIP_COLUMNS),
      .COLUMNS      (COLUMNS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_width       (req_width),
      .req_height      (req_height),
      .req_pixel_value (req_pixel_value),
      .req_chip        (req_chip),
      .req_scan_line   (req_scan_line),
      .ctl             (ctl),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd)
   );

   lfs_back #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .gain            (gain_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .ctl             (ctl),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_pwm_index   (rsp_pwm_index),
      .rsp_ok          (rsp_ok),
      .rsp_error_count (rsp_error_count),
      .rsp_last        (rsp_last)
   );

endmodule

### tb/led_framebuffer_scanout_test.sv
// Self-checking testbench of the LED frame store and scan-out block.
module led_framebuffer_scanout_test;

   localparam int FRAME_ROWS     = 12;
   localparam int DRIVER_COLUMNS = 7;
   localparam int FRAME_COLS     = 42;
   localparam int GAIN_DIV       = 255;
   localparam int RESET_CYCLES   = 6;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 25;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES   = FRAME_ROWS * FRAME_COLS + 32;
   localparam int CYCLE_LIMIT    = 1000000;

   localparam logic [2:0] GAIN_ADDR         = 3'd0;
   localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] width;
      logic [7:0] height;
      logic [7:0] pixel_value;
      logic [2:0] chip;
      logic [3:0] scan_line;
   } req_type;

   typedef struct packed {
      logic [7:0]  data;
      logic [7:0]  pwm_index;
      logic        ok;
      logic [31:0] error_count;
      logic        last;
   } beat_type;

   // One directed step; known rows carry their single beat written out by hand
   typedef struct packed {
      req_type     req;
      logic        known;
      logic [7:0]  data;
      logic        ok;
      logic [31:0] errs;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_x_pos = '0;
   logic [7:0]  req_y_pos = '0;
   logic [7:0]  req_width = '0;
   logic [7:0]  req_height = '0;
   logic [7:0]  req_pixel_value = '0;
   logic [2:0]  req_chip = '0;
   logic [3:0]  req_scan_line = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data;
   logic [7:0]  rsp_pwm_index;
   logic        rsp_ok;
   logic [31:0] rsp_error_count;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the frame store, gain register and failure counter
   logic [7:0]  pixels [FRAME_ROWS][FRAME_COLS] = '{default: 8'd0};
   logic [7:0]  gain_model = lfs_pkg::GAIN_RESET;
   logic [31:0] set_failures = '0;
   beat_type    awaited_beats [$];
   beat_type    head_beat;
   int          failures_seen = 0;
   int          cycle_count = 0;
   int          gap_odds = 0;
   logic        calm = 1'b0;
   int          hold_asks = 0;
   int          hold_done = 0;
   int          rx_hold_left = 0;
   int          rx_stall_left = 0;
   int          rx_quiet_left = 0;

   step_row_type directed_rows [0:28] = '{
      '{'{lfs_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SET, 0, 0, 0, 0, 255, 0, 0}, 1, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SET, 41, 11, 0, 0, 1, 0, 0}, 1, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SET, 42, 0, 0, 0, 9, 0, 0}, 1, 0, 0, 1},
      '{'{lfs_pkg::FUNC_SET, 0, 12, 0, 0, 9, 0, 0}, 1, 0, 0, 2},
      '{'{lfs_pkg::FUNC_SET, 255, 255, 255, 255, 9, 7, 15}, 1, 0, 0, 3},
      '{'{lfs_pkg::FUNC_READ, 255, 255, 0, 0, 0, 0, 0}, 1, 0, 1, 3},
      '{'{lfs_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0}, 1, 255, 1, 3},
      '{'{lfs_pkg::FUNC_READ, 41, 11, 0, 0, 0, 0, 0}, 1, 1, 1, 3},
      '{'{lfs_pkg::FUNC_SET, 6, 0, 0, 0, 255, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SET, 6, 11, 0, 0, 200, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 5, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_RECT, 40, 10, 255, 255, 17, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_RECT, 3, 2, 10, 4, 77, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_RECT, 30, 8, 200, 200, 170, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_RECT, 42, 0, 5, 5, 99, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_RECT, 5, 5, 0, 3, 99, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 5, 6}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 6, 2}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 7, 15}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 2, 7}, 0, 0, 1, 0},
      '{'{FUNC_FIRST_UNUSED, 3, 4, 5, 6, 7, 1, 2}, 1, 0, 1, 3},
      '{'{FUNC_LAST_UNUSED, 255, 255, 255, 255, 255, 7, 15}, 1, 0, 1, 3},
      '{'{lfs_pkg::FUNC_FILL, 0, 0, 0, 0, 255, 0, 0}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_SCAN, 0, 0, 0, 0, 0, 3, 3}, 0, 0, 1, 0},
      '{'{lfs_pkg::FUNC_FILL, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 1, 3},
      '{'{lfs_pkg::FUNC_READ, 41, 11, 0, 0, 0, 0, 0}, 1, 0, 1, 3}
   };

   led_framebuffer_scanout #(
      .ROWS(FRAME_ROWS),
      .CHIP_COLUMNS(DRIVER_COLUMNS),
      .COLUMNS(FRAME_COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_x_pos(req_x_pos),
      .req_y_pos(req_y_pos),
      .req_width(req_width),
      .req_height(req_height),
      .req_pixel_value(req_pixel_value),
      .req_chip(req_chip),
      .req_scan_line(req_scan_line),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .rsp_pwm_index(rsp_pwm_index),
      .rsp_ok(rsp_ok),
      .rsp_error_count(rsp_error_count),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         failures_seen++;
      end
   endfunction

   // Compare each result beat with the oldest awaited one
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_beats.size() == 0) begin
            $error("result beat with none awaited: data %0d pwm_index %0d",
                   rsp_data, rsp_pwm_index);
            failures_seen++;
         end else begin
            head_beat = awaited_beats.pop_front();
            check_field("data", 32'(head_beat.data), 32'(rsp_data));
            check_field("pwm_index", 32'(head_beat.pwm_index), 32'(rsp_pwm_index));
            check_field("ok", 32'(head_beat.ok), 32'(rsp_ok));
            check_field("error_count", head_beat.error_count, rsp_error_count);
            check_field("last", 32'(head_beat.last), 32'(rsp_last));
         end
      end
   end

   // Receiver: long hold on request, random stalls, quiet stretches
   always @(posedge clock) begin
      if (rx_hold_left != 0) begin
         rsp_ready <= (rx_hold_left == 1);
         rx_hold_left <= rx_hold_left - 1;
      end else if (hold_asks != hold_done) begin
         hold_done <= hold_asks;
         rx_hold_left <= RX_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
         rsp_ready <= (rx_stall_left == 1);
         rx_stall_left <= rx_stall_left - 1;
      end else if (rx_quiet_left != 0) begin
         rsp_ready <= 1'b1;
         rx_quiet_left <= rx_quiet_left - 1;
      end else if (calm || $urandom_range(0, 5) != 0) begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 39) == 0)
            rx_quiet_left <= $urandom_range(20, 80);
      end else begin
         rsp_ready <= 1'b0;
         rx_stall_left <= $urandom_range(1, 11);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Apply one request to the shadow frame and queue the beats it causes
   task automatic predict_beats(input req_type r);
      int         col;
      int         s;
      int         row;
      int         column;
      int         x_stop;
      int         y_stop;
      bit         on_frame;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [7:0] read_back;
      logic [7:0] scaled;
      logic       pass;
      bit         in_frame;
      read_back = '0;
      pass = 1'b1;
      in_frame = r.x_pos < FRAME_COLS && r.y_pos < FRAME_ROWS;
      if (r.func == lfs_pkg::FUNC_SCAN) begin
         on_frame = 1'b0;
         col = 0;
         if (r.scan_line < DRIVER_COLUMNS) begin
            col = int'(r.chip) * DRIVER_COLUMNS + (DRIVER_COLUMNS - 1 - int'(r.scan_line));
            on_frame = col < FRAME_COLS;
         end
         for (s = 0; s < lfs_pkg::SOURCES; s++) begin
            scaled = '0;
            if (on_frame && s < FRAME_ROWS)
               scaled = 8'(int'(pixels[s][col]) * int'(gain_model) / GAIN_DIV);
            awaited_beats.push_back('{scaled,
                                      8'(int'(r.scan_line) * lfs_pkg::SOURCES + s), 1'b1,
                                      set_failures, s == lfs_pkg::SOURCES - 1});
         end
         return;
      end
      case (r.func)
         lfs_pkg::FUNC_SET: begin
            if (in_frame) begin
               pixels[r.y_pos][r.x_pos] = r.pixel_value;
            end else begin
               pass = 1'b0;
               set_failures = set_failures + 1;
            end
         end
         lfs_pkg::FUNC_READ: begin
            if (in_frame)
               read_back = pixels[r.y_pos][r.x_pos];
         end
         lfs_pkg::FUNC_RECT: begin
            if (in_frame) begin
               // end corner wraps at 8 bits before clipping
               x_end = r.x_pos + r.width;
               y_end = r.y_pos + r.height;
               x_stop = (x_end > FRAME_COLS) ? FRAME_COLS : int'(x_end);
               y_stop = (y_end > FRAME_ROWS) ? FRAME_ROWS : int'(y_end);
               for (row = int'(r.y_pos); row < y_stop; row++)
                  for (column = int'(r.x_pos); column < x_stop; column++)
                     pixels[row][column] = r.pixel_value;
            end
         end
         lfs_pkg::FUNC_FILL: begin
            for (row = 0; row < FRAME_ROWS; row++)
               for (column = 0; column < FRAME_COLS; column++)
                  pixels[row][column] = r.pixel_value;
         end
         default: begin
         end
      endcase
      awaited_beats.push_back('{read_back, 8'd0, pass, set_failures, 1'b1});
   endtask

   // Offer one request beat, hold it until taken, then predict
   task automatic offer(input req_type r);
      if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= r.func;
      req_x_pos <= r.x_pos;
      req_y_pos <= r.y_pos;
      req_width <= r.width;
      req_height <= r.height;
      req_pixel_value <= r.pixel_value;
      req_chip <= r.chip;
      req_scan_line <= r.scan_line;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_beats(r);
   endtask

   // Drop valid and wait for every awaited beat, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic read_gain(output logic [31:0] got);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= GAIN_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the gain register, then read it back
   task automatic set_gain(input logic [7:0] gain);
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= GAIN_ADDR;
      csr_pwdata <= {24'd0, gain};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      gain_model = gain;
      read_gain(got);
      check_field("global_gain", {24'd0, gain}, got);
   endtask

   // Mostly well-formed requests on the frame, with raw noise mixed in
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.func = 3'($urandom_range(0, 7));
      r.x_pos = 8'($urandom_range(0, 255));
      r.y_pos = 8'($urandom_range(0, 255));
      r.width = 8'($urandom_range(0, 255));
      r.height = 8'($urandom_range(0, 255));
      r.pixel_value = 8'($urandom_range(0, 255));
      r.chip = 3'($urandom_range(0, 7));
      r.scan_line = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         r.func = lfs_pkg::FUNC_SET;
         if (pick < 25) begin
            r.x_pos = 8'($urandom_range(0, FRAME_COLS - 1));
            r.y_pos = 8'($urandom_range(0, FRAME_ROWS - 1));
         end
      end else if (pick < 46) begin
         r.func = lfs_pkg::FUNC_READ;
         if (pick < 43) begin
            r.x_pos = 8'($urandom_range(0, FRAME_COLS - 1));
            r.y_pos = 8'($urandom_range(0, FRAME_ROWS - 1));
         end
      end else if (pick < 60) begin
         r.func = lfs_pkg::FUNC_RECT;
         if (pick < 58) begin
            r.x_pos = 8'($urandom_range(0, FRAME_COLS - 1));
            r.y_pos = 8'($urandom_range(0, FRAME_ROWS - 1));
         end
         if (pick < 56) begin
            r.width = 8'($urandom_range(0, 16));
            r.height = 8'($urandom_range(0, 5));
         end
      end else if (pick < 63) begin
         r.func = lfs_pkg::FUNC_FILL;
      end else if (pick < 94) begin
         r.func = lfs_pkg::FUNC_SCAN;
         if (pick < 88) begin
            r.chip = 3'($urandom_range(0, 5));
            r.scan_line = 4'($urandom_range(0, DRIVER_COLUMNS - 1));
         end
      end else begin
         r.func = 3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
      end
      return r;
   endfunction

   initial begin
      int           phase;
      int           item;
      logic [7:0]   gain;
      logic [31:0]  got;
      step_row_type row;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      read_gain(got);
      check_field("global_gain", {24'd0, lfs_pkg::GAIN_RESET}, got);

      // Walk the directed steps at the reset gain
      gap_odds = 1;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer(row.req);
         if (row.known)
            awaited_beats[awaited_beats.size() - 1] = '{row.data, 8'd0, row.ok, row.errs, 1'b1};
      end

      // Random phases, each after a gain write; first one backs up the block, last runs calm
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: gain = 8'd255;
            1: gain = 8'd0;
            2: gain = 8'd1;
            PHASES - 1: gain = 8'd255;
            default: gain = 8'($urandom_range(2, 254));
         endcase
         set_gain(gain);
         gap_odds = $urandom_range(0, 3);
         if (phase == 0) begin
            gap_odds = 0;
            hold_asks <= hold_asks + 1;
         end
         if (phase == PHASES - 1) begin
            gap_odds = 0;
            calm <= 1'b1;
         end
         for (item = 0; item < PHASE_ITEMS; item++)
            offer(random_request());
      end

      drain_results();
      if (failures_seen == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### files.f
src/lfs_pkg.sv
src/lfs_front.sv
src/lfs_back.sv
src/led_framebuffer_scanout.sv
tb/led_framebuffer_scanout_test.sv
